FILE: src/odcps_pkg.sv
// Shared types and constants for the oldest-due channel poll scheduler.
// No dependencies; used by odcps_ctrl, odcps_dp and the top level.
package odcps_pkg;

  localparam int MAX_CHANNELS_DEF = 32;

  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int SERIAL_W   = 32;
  localparam int ENTRY_IDX_W = 5;
  localparam int INTERVAL_W = 16;
  localparam int ACTIVE_W   = 6;
  localparam int INHIBIT_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_INHIBIT = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INHIBIT_SEC   = 2'd2;

  localparam logic [INHIBIT_W-1:0] INHIBIT_RESET = 8'd45;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic stamp;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic qualify;
    logic scan_done;
    logic out_busy;
  } ctrl_sts_t;

endpackage

FILE: src/oldest_due_channel_poll_scheduler.sv
// Oldest-due channel poll scheduler, top level.
// Instantiates odcps_ctrl and odcps_dp; uses odcps_pkg.
//
// Requests arrive on the in_ channel; in_tuser carries the op code (tick,
// inhibit, table write). Each request yields exactly one result on out_.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write
// them only while idle, and the block itself does not enforce this. Inhibit,
// table write and non-polling ticks go from acceptance straight to the
// hand-off step, which loads the result register. A polling tick walks the
// first min(active_channels, MAX_CHANNELS) entries one per cycle through the
// table read port plus one compare stage, then stamps the chosen entry, if
// any, and hands off. The sequencer is back in idle when the result turns valid.
// One request is handled at a time; in_tready is high whenever the
// sequencer is idle, also while an earlier result waits in the output
// register. If the receiver stalls, the finished result is held and the
// next request waits in the hand-off step until the output register frees.
// Reset clears the sequencer, the feedback flags (no channel is pollable),
// the inhibit deadline and the config registers (inhibit length 45 s).
// Serials and last-poll times hold no defined value until written.
module oldest_due_channel_poll_scheduler #(
  parameter int MAX_CHANNELS = odcps_pkg::MAX_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [odcps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odcps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // now_s[31:0], time_valid[32], radio_ready[33], entry_index[38:34],
  // entry_serial[70:39], entry_feedback[71], entry_last_poll[103:72]
  input  logic [odcps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // op[1:0]
  input  logic [odcps_pkg::OP_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // poll_serial[31:0], poll_index[36:32], zero[39:37]
  output logic [odcps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // poll_issued[0]
  output logic                               out_tuser
);

  odcps_pkg::ctrl_cmd_t cmd;
  odcps_pkg::ctrl_sts_t sts;

  odcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odcps_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: src/odcps_ctrl.sv
// Sequencer for the poll scheduler: accept, scan, stamp and result hand-off.
// Depends on odcps_pkg for the command and status structs.
module odcps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  odcps_pkg::ctrl_sts_t  sts,
  output odcps_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.qualify ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.stamp = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy) else $error("result loaded over pending result");

  a_stamp_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stamp |-> sts.scan_done) else $error("stamp before scan finished");

  a_scan_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stamp |=> (state_r == S_FIN)) else $error("no hand-off after stamp");

endmodule

FILE: src/odcps_dp.sv
// Datapath for the poll scheduler: config registers, channel table,
// scan compare stage, inhibit deadline and result register. Uses odcps_pkg.
module odcps_dp #(
  parameter int MAX_CHANNELS = odcps_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [odcps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [odcps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [odcps_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [odcps_pkg::OP_W-1:0]           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [odcps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tuser,
  input  odcps_pkg::ctrl_cmd_t                 cmd,
  output odcps_pkg::ctrl_sts_t                 sts
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W = (CNT_W > odcps_pkg::ACTIVE_W) ? CNT_W : odcps_pkg::ACTIVE_W;
  localparam int EIX_W = (CNT_W > odcps_pkg::ENTRY_IDX_W) ? CNT_W : odcps_pkg::ENTRY_IDX_W;
  localparam int TW = odcps_pkg::TIME_W;
  localparam int SW = odcps_pkg::SERIAL_W;

  // input fields
  logic [TW-1:0]                        now_s;
  logic                                 time_valid;
  logic                                 radio_ready;
  logic [odcps_pkg::ENTRY_IDX_W-1:0]    entry_index;
  logic [SW-1:0]                        entry_serial;
  logic                                 entry_feedback;
  logic [TW-1:0]                        entry_last_poll;

  assign now_s           = in_tdata[31:0];
  assign time_valid      = in_tdata[32];
  assign radio_ready     = in_tdata[33];
  assign entry_index     = in_tdata[38:34];
  assign entry_serial    = in_tdata[70:39];
  assign entry_feedback  = in_tdata[71];
  assign entry_last_poll = in_tdata[103:72];

  // config
  logic [odcps_pkg::INTERVAL_W-1:0] interval_r;
  logic [odcps_pkg::ACTIVE_W-1:0]   active_r;
  logic [odcps_pkg::INHIBIT_W-1:0]  inhibit_sec_r;
  logic [TW-1:0]                    deadline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r    <= '0;
      active_r      <= '0;
      inhibit_sec_r <= odcps_pkg::INHIBIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        odcps_pkg::REG_POLL_INTERVAL: interval_r    <= cfg_wdata;
        odcps_pkg::REG_ACTIVE:        active_r      <= cfg_wdata[odcps_pkg::ACTIVE_W-1:0];
        odcps_pkg::REG_INHIBIT_SEC:   inhibit_sec_r <= cfg_wdata[odcps_pkg::INHIBIT_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode
  logic is_tick, is_inhibit, is_write, idx_in_range, qualify;
  logic [TW:0] deadline_sum;
  logic [IDX_W-1:0] wr_addr;

  assign is_tick      = (in_tuser == odcps_pkg::OP_TICK);
  assign is_inhibit   = (in_tuser == odcps_pkg::OP_INHIBIT);
  assign is_write     = (in_tuser == odcps_pkg::OP_WRITE);
  assign idx_in_range = (EIX_W'(entry_index) < EIX_W'(MAX_CHANNELS));
  assign wr_addr      = IDX_W'(entry_index);
  assign qualify      = is_tick && time_valid && radio_ready &&
                        (now_s >= deadline_r) && (interval_r != '0);
  assign deadline_sum = {1'b0, now_s} + {{(TW + 1 - odcps_pkg::INHIBIT_W){1'b0}}, inhibit_sec_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
    end else if (cmd.accept && is_inhibit && (now_s != '0)) begin
      deadline_r <= deadline_sum[TW] ? {TW{1'b1}} : deadline_sum[TW-1:0];
    end
  end

  // channel table
  logic [SW-1:0] serial_mem [MAX_CHANNELS];
  logic [TW-1:0] last_mem   [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] fb_r;

  logic [TW-1:0]    now_r;
  logic             tick_sel_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             rdv_r;
  logic             rd_fb_r;
  logic [IDX_W-1:0] idx_q_r;
  logic [SW-1:0]    rd_serial_r;
  logic [TW-1:0]    rd_ts_r;
  logic [SW-1:0]    best_serial_r;
  logic [TW-1:0]    best_ts_r;
  logic [IDX_W-1:0] best_idx_r;

  logic             last_we;
  logic [IDX_W-1:0] last_addr;
  logic [TW-1:0]    last_wdata;
  logic             stamp_en;

  assign stamp_en   = cmd.stamp && (best_serial_r != '0);
  assign last_we    = (cmd.accept && is_write && idx_in_range) || stamp_en;
  assign last_addr  = stamp_en ? best_idx_r : wr_addr;
  assign last_wdata = stamp_en ? now_r : entry_last_poll;

  always_ff @(posedge clk) begin
    if (cmd.accept && is_write && idx_in_range) begin
      serial_mem[wr_addr] <= entry_serial;
    end
    if (last_we) begin
      last_mem[last_addr] <= last_wdata;
    end
    rd_serial_r <= serial_mem[rd_idx_r[IDX_W-1:0]];
    rd_ts_r     <= last_mem[rd_idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else if (cmd.accept && is_write && idx_in_range) begin
      fb_r[wr_addr] <= entry_feedback;
    end
  end

  // scan
  logic [CMP_W-1:0] act_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CNT_W-1:0] count_nxt;
  logic             rd_issue;
  logic [TW-1:0]    age;
  logic             eligible;
  logic             take;

  assign act_ext   = CMP_W'(active_r);
  assign max_ext   = CMP_W'(MAX_CHANNELS);
  assign count_nxt = CNT_W'((act_ext > max_ext) ? max_ext : act_ext);
  assign rd_issue  = cmd.scan_step && (rd_idx_r < count_r);
  assign age       = now_r - rd_ts_r;
  assign eligible  = (rd_ts_r == '0) ||
                     ((now_r >= rd_ts_r) && (age >= TW'(interval_r)));
  assign take      = rdv_r && rd_fb_r && eligible &&
                     ((best_serial_r == '0) || (rd_ts_r < best_ts_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_sel_r <= 1'b0;
      rd_idx_r   <= '0;
      rdv_r      <= 1'b0;
      count_r    <= '0;
    end else if (cmd.accept) begin
      tick_sel_r <= qualify;
      rd_idx_r   <= '0;
      rdv_r      <= 1'b0;
      count_r    <= count_nxt;
    end else begin
      rdv_r <= rd_issue;
      if (rd_issue) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r         <= now_s;
      best_serial_r <= '0;
      best_ts_r     <= now_s;
      best_idx_r    <= '0;
    end else if (take) begin
      best_serial_r <= rd_serial_r;
      best_ts_r     <= rd_ts_r;
      best_idx_r    <= idx_q_r;
    end
    rd_fb_r <= fb_r[rd_idx_r[IDX_W-1:0]];
    idx_q_r <= rd_idx_r[IDX_W-1:0];
  end

  // result register
  logic                              out_valid_r;
  logic                              res_issued_r;
  logic [SW-1:0]                     res_serial_r;
  logic [odcps_pkg::ENTRY_IDX_W-1:0] res_idx_r;
  logic                              issued;

  assign issued = tick_sel_r && (best_serial_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_issued_r <= issued;
      res_serial_r <= issued ? best_serial_r : '0;
      res_idx_r    <= issued ? odcps_pkg::ENTRY_IDX_W'(best_idx_r) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_issued_r;
  assign out_tdata  = {3'b000, res_idx_r, res_serial_r};

  assign sts.qualify   = qualify;
  assign sts.scan_done = (rd_idx_r >= count_r) && !rdv_r;
  assign sts.out_busy  = out_valid_r && !out_tready;

  a_issued_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[31:0] != '0))
    else $error("issued poll with zero serial");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rdv_r |-> (CNT_W'(idx_q_r) < count_r)) else $error("scan beyond active count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_CHANNELS)) else $error("scan count above table size");

endmodule
